FILE: rtl/qpsk_symbol_modulator_assert.svh
// Assertion macros for the QPSK symbol modulator checker
`ifndef QPSK_SYMBOL_MODULATOR_ASSERT_SVH
`define QPSK_SYMBOL_MODULATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held
`define QSM_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("qsm: same-cycle check failed");

// Next-cycle implication, switched off while reset is held
`define QSM_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("qsm: next-cycle check failed");

`endif

FILE: rtl/qsm_pkg.sv
// Types, constants and wave lookup functions for the QPSK symbol modulator
package qsm_pkg;

  localparam int SAMPLES_PER_SYMBOL = 15;
  localparam int CARRIER_PERIOD     = 18;

  localparam int CIRCLE_STEPS  = 72;
  localparam int QUARTER_STEPS = 18;
  localparam int STEP_W        = $clog2(CIRCLE_STEPS);
  localparam int PHASE_W       = $clog2(CARRIER_PERIOD);
  localparam int SPS_W         = $clog2(SAMPLES_PER_SYMBOL + 1);

  localparam int LIMIT_W       = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd18000;

  localparam int SAMPLE_W      = 32;
  localparam int QWAVE_N       = 9;
  localparam int QWAVE_W       = $clog2(QWAVE_N);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // trunc(0x7F000000 * sin(d)) for d = 5, 15, ..., 85 degrees
  localparam logic [SAMPLE_W-1:0] QUARTER_WAVE [QWAVE_N] = '{
    32'd185703301,  32'd551467404,  32'd900475448,
    32'd1222123002, 32'd1506636966, 32'd1745372529,
    32'd1931075831, 32'd2058104370, 32'd2122598450
  };

  // Phase offset in 72nds of a turn, indexed by {first_bit, second_bit}
  localparam logic [STEP_W-1:0] SYMBOL_OFFSET [4] = '{
    7'd27, 7'd9, 7'd45, 7'd63
  };

  typedef struct packed {
    logic first_bit;
    logic second_bit;
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       overflow;
  } out_item_t;

  // Classified symbol handed from the front to the back
  typedef struct packed {
    logic [STEP_W-1:0] offset;
    logic              restart;
  } cmd_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Table step of a carrier phase: 2 * floor(phase * 36 / period), as a constant table
  function automatic logic [STEP_W-1:0] phase_base(input logic [PHASE_W-1:0] ph);
    logic [STEP_W-1:0] base;
    base = '0;
    for (int i = 0; i < CARRIER_PERIOD; i++) begin
      if (ph == PHASE_W'(i)) begin
        base = STEP_W'((i * 36 / CARRIER_PERIOD) * 2);
      end
    end
    return base;
  endfunction

  // Sine sample at an odd step of the 72-step circle, folded from a quarter wave
  function automatic logic signed [SAMPLE_W-1:0] wave_lookup(input logic [STEP_W-1:0] n);
    logic [1:0]         quad;
    logic [4:0]         r;
    logic [4:0]         rm;
    logic [QWAVE_W-1:0] idx;
    logic [SAMPLE_W-1:0] v;
    if (n >= STEP_W'(3 * QUARTER_STEPS)) begin
      quad = 2'd3;
      r    = 5'(n - STEP_W'(3 * QUARTER_STEPS));
    end else if (n >= STEP_W'(2 * QUARTER_STEPS)) begin
      quad = 2'd2;
      r    = 5'(n - STEP_W'(2 * QUARTER_STEPS));
    end else if (n >= STEP_W'(QUARTER_STEPS)) begin
      quad = 2'd1;
      r    = 5'(n - STEP_W'(QUARTER_STEPS));
    end else begin
      quad = 2'd0;
      r    = 5'(n);
    end
    if (quad[0]) begin
      r = 5'(QUARTER_STEPS) - r;
    end
    rm  = r - 5'd1;
    idx = QWAVE_W'(rm >> 1);
    if (idx >= QWAVE_W'(QWAVE_N)) begin
      idx = idx - QWAVE_W'(QWAVE_N);
    end
    v = QUARTER_WAVE[idx];
    if (quad[1]) begin
      v = -v;
    end
    return signed'(v);
  endfunction

endpackage

FILE: rtl/qsm_front.sv
// Front end: takes symbols, looks up their phase offset, pushes commands
module qsm_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  qsm_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output qsm_pkg::cmd_t    q_cmd
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.offset  = qsm_pkg::SYMBOL_OFFSET[{in_data.first_bit, in_data.second_bit}];
    q_cmd.restart = in_data.restart;
  end

endmodule

FILE: rtl/qsm_queue.sv
// Short command queue between front and back
module qsm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qsm_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output qsm_pkg::q_head_t  head
);

  qsm_pkg::cmd_t                   mem_r [qsm_pkg::QUEUE_DEPTH];
  logic [qsm_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [qsm_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [qsm_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full       = (cnt_r == qsm_pkg::QCNT_W'(qsm_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == qsm_pkg::QPTR_W'(qsm_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + qsm_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == qsm_pkg::QPTR_W'(qsm_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + qsm_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + qsm_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - qsm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/qsm_back.sv
// Back end: sample sequencer, carrier state and output register
module qsm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qsm_pkg::LIMIT_W-1:0]    cfg_wdata,
  input  qsm_pkg::q_head_t               head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output qsm_pkg::out_item_t             out_data
);

  logic [qsm_pkg::LIMIT_W-1:0]  limit_r;
  logic [qsm_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [qsm_pkg::LIMIT_W-1:0]  count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         busy_r, busy_nxt;
  logic [qsm_pkg::SPS_W-1:0]    j_r, j_nxt;
  logic [qsm_pkg::STEP_W-1:0]   off_r, off_nxt;
  logic                         out_valid_r, out_valid_nxt;
  qsm_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                         advance, fire, clr;
  logic [qsm_pkg::PHASE_W-1:0]  cur_phase;
  logic [qsm_pkg::LIMIT_W-1:0]  cur_count;
  logic                         cur_ovf, hit, final_smp;
  logic [qsm_pkg::SPS_W-1:0]    cur_j;
  logic [qsm_pkg::STEP_W-1:0]   cur_off;
  logic [qsm_pkg::STEP_W:0]     step_sum;
  logic [qsm_pkg::STEP_W-1:0]   step;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && !busy_r && head.valid;
  assign fire    = advance && (busy_r || head.valid);
  assign clr     = pop && head.cmd.restart;

  always_comb begin
    cur_phase = clr ? '0   : phase_r;
    cur_count = clr ? '0   : count_r;
    cur_ovf   = clr ? 1'b0 : ovf_r;
    cur_j     = busy_r ? j_r   : '0;
    cur_off   = busy_r ? off_r : head.cmd.offset;
    hit       = cur_ovf || (cur_count >= limit_r);
    final_smp = (cur_j == qsm_pkg::SPS_W'(qsm_pkg::SAMPLES_PER_SYMBOL - 1));
    step_sum  = {1'b0, qsm_pkg::phase_base(cur_phase)} + {1'b0, cur_off};
    step      = (step_sum >= (qsm_pkg::STEP_W + 1)'(qsm_pkg::CIRCLE_STEPS))
                ? qsm_pkg::STEP_W'(step_sum - (qsm_pkg::STEP_W + 1)'(qsm_pkg::CIRCLE_STEPS))
                : qsm_pkg::STEP_W'(step_sum);
  end

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    j_nxt         = j_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = fire;
    end
    if (fire) begin
      phase_nxt = cur_phase;
      count_nxt = cur_count;
      ovf_nxt   = cur_ovf;
      if (hit) begin
        // Limit reached: one marker closes this symbol
        ovf_nxt               = 1'b1;
        busy_nxt              = 1'b0;
        out_data_nxt.sample   = '0;
        out_data_nxt.last     = 1'b1;
        out_data_nxt.overflow = 1'b1;
      end else begin
        out_data_nxt.sample   = qsm_pkg::wave_lookup(step);
        out_data_nxt.last     = final_smp;
        out_data_nxt.overflow = 1'b0;
        count_nxt = cur_count + qsm_pkg::LIMIT_W'(1);
        phase_nxt = (cur_phase == qsm_pkg::PHASE_W'(qsm_pkg::CARRIER_PERIOD - 1)) ? '0
                    : cur_phase + qsm_pkg::PHASE_W'(1);
        j_nxt     = cur_j + qsm_pkg::SPS_W'(1);
        off_nxt   = cur_off;
        busy_nxt  = !final_smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= qsm_pkg::LIMIT_RESET;
      phase_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/qpsk_symbol_modulator.sv
// Top level of the QPSK symbol modulator: front, command queue and sample back end
//
//   Channel   Ports                          Carries
//   input     in_valid/in_ready/in_data      one two-bit symbol plus restart flag
//   output    out_valid/out_ready/out_data   one PCM sample, last and overflow flags
//   config    cfg_we/cfg_wdata               sample_limit, written without wait
//
// The sample sequencer gives 15 samples per symbol, one per cycle unless out_ready
// stalls the back end; a symbol that hits the limit ends in one overflow marker.
// Reset is synchronous on rst_n; the limit returns to 18000, counters to zero.
// A two-entry command queue lets the front keep taking symbols while the back
// end is stalled by out_ready; the output register holds a transaction until taken.
module qpsk_symbol_modulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  qsm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output qsm_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [qsm_pkg::LIMIT_W-1:0] cfg_wdata
);

  // Front to queue
  logic             q_push;
  logic             q_full;
  qsm_pkg::cmd_t    q_cmd;

  // Queue to back
  logic             q_pop;
  qsm_pkg::q_head_t q_head;

  // Classify each symbol into its phase offset and restart request
  qsm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Hold pending commands so each side can stall on its own
  qsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Advance the carrier, count samples against the limit, drive the output
  qsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/qsm_checker.sv
// Port-level checker for the QPSK symbol modulator, bound to the top level
`include "qpsk_symbol_modulator_assert.svh"

module qsm_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  qsm_pkg::out_item_t          out_data
);

  // A stalled result transaction keeps its payload
  `QSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // An overflow marker always closes its symbol
  `QSM_ASSERT_IMPL(a_ovf_last, clk, rst_n, out_valid && out_data.overflow, out_data.last)

  // An overflow marker carries no sample
  `QSM_ASSERT_IMPL(a_ovf_zero, clk, rst_n, out_valid && out_data.overflow, out_data.sample == 0)

  // Real samples never fall on a zero crossing
  `QSM_ASSERT_IMPL(a_smp_nonzero, clk, rst_n, out_valid && !out_data.overflow, out_data.sample != 0)

endmodule

bind qpsk_symbol_modulator qsm_checker u_qsm_checker (.*);
